FILE: hdl/htach_pkg.sv
// shared types and constants for the hall tachometer
package htach_pkg;

  localparam int TICK_W      = 32;
  localparam int TIMEOUT_W   = 16;
  localparam int PERIOD_W    = 10;
  localparam int RPM_W       = 22;
  localparam int PROD_W      = TICK_W + PERIOD_W;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [RPM_W-1:0]     RPM_MAX       = 22'd3000000;
  localparam int                   MS_PER_MINUTE = 60000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 10'd1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD  = 1'd1;

  // request classes produced by the front end
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_HALL_LOW  = 2'd1;
  localparam logic [OP_W-1:0] OP_HALL_HIGH = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
  } queue_head_t;

endpackage

FILE: hdl/hall_tachometer_rpm.sv
// top level of the hall sensor tachometer
// tick and low-level hall requests: queued in the front, then the back end registers the result as it takes them
// high-level hall requests: the back end steps through ring read, multiply and the
//   one-bit-per-cycle serial divider; the back end takes one request at a time
// the two-entry front queue keeps accepting, until it is full, while the back end computes or a result waits
// synchronous active-high reset clears counters, speed, ring valid bits and loads
//   the register defaults (timeout 100 ticks, 1 ms per tick); no clearing pass
module hall_tachometer_rpm #(
  parameter int SAMPLES = 50
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              req_type,
  input  logic                              hall_level,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [htach_pkg::RPM_W-1:0]       rpm,
  output logic                              timed_out,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [htach_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [htach_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import htach_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [PERIOD_W-1:0]  tick_period_ms;
  queue_head_t          head;
  logic                 pop;

  // register writes are always taken; software is to write only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= TIMEOUT_RESET;
      tick_period_ms <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_ticks  <= cfg_data;
        CFG_PERIOD:  tick_period_ms <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: classify each request as tick, hall low or hall high and queue it
  htach_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .req_type   (req_type),
    .hall_level (hall_level),
    .head       (head),
    .pop        (pop)
  );

  // back: counters, timestamp ring and the serial speed divide
  htach_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .timeout_ticks  (timeout_ticks),
    .tick_period_ms (tick_period_ms),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .rpm            (rpm),
    .timed_out      (timed_out)
  );

endmodule

FILE: hdl/htach_ram.sv
// generic single-write, single-read ram with registered read data
module htach_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/htach_front.sv
// front end: classifies requests and holds them in a two-entry queue
module htach_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  req_type,
  input  logic                  hall_level,
  output htach_pkg::queue_head_t head,
  input  logic                  pop
);
  import htach_pkg::*;

  logic [OP_W-1:0] entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic [OP_W-1:0] op_in;

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;

  always_comb begin
    if (!req_type) begin
      op_in = OP_TICK;
    end else if (hall_level) begin
      op_in = OP_HALL_HIGH;
    end else begin
      op_in = OP_HALL_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.op    = entry[rd_ptr];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("pop from empty queue");

endmodule

FILE: hdl/htach_div.sv
// serial restoring divider: constant numerator over a variable divisor
module htach_div #(
  parameter int NUMER = 3000000,
  parameter int DIV_W = 42
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [DIV_W-1:0]                 divisor,
  output logic                             done,
  output logic [$clog2(NUMER+1)-1:0]       quotient
);

  localparam int NUM_W = $clog2(NUMER + 1);
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int CMP_W = (DIV_W > NUM_W + 1) ? DIV_W : NUM_W + 1;

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [NUM_W:0]   rem_sh;
  logic             ge;
  logic [CMP_W-1:0] diff;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = CMP_W'(rem_sh) >= CMP_W'(dvs);
  assign diff   = CMP_W'(rem_sh) - CMP_W'(dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        quo  <= NUM_W'(NUMER);
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: hdl/htach_back.sv
// back end: tick and timeout state, timestamp ring, speed computation
module htach_back #(
  parameter int SAMPLES = 50
) (
  input  logic                            clk,
  input  logic                            rst,
  input  htach_pkg::queue_head_t          head,
  output logic                            pop,
  input  logic [htach_pkg::TIMEOUT_W-1:0] timeout_ticks,
  input  logic [htach_pkg::PERIOD_W-1:0]  tick_period_ms,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [htach_pkg::RPM_W-1:0]     rpm,
  output logic                            timed_out
);
  import htach_pkg::*;

  localparam int SLOT_W = $clog2(SAMPLES);
  localparam int NUMER  = MS_PER_MINUTE * SAMPLES;
  localparam int NUM_W  = $clog2(NUMER + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]           state;
  logic [TICK_W-1:0]    tick_count;
  logic [TIMEOUT_W-1:0] timeout_count;
  logic                 activity_seen;
  logic [RPM_W-1:0]     speed_value;
  logic [SLOT_W-1:0]    write_slot;
  logic [SAMPLES-1:0]   stamp_valid;
  logic                 old_valid;
  logic [TICK_W-1:0]    span;
  logic [PROD_W-1:0]    prod;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     quotient;
  logic [TICK_W-1:0]    rd_data;
  logic [SLOT_W-1:0]    slot_next;
  logic                 stamp_we;
  logic [TIMEOUT_W-1:0] period;
  logic [TIMEOUT_W-1:0] tc_inc;
  logic                 check_due;
  logic [RPM_W-1:0]     speed_sat;
  logic                 result_load;

  assign pop = head.valid && (state == S_IDLE) && (!result_valid || !result_stall);

  assign slot_next = (write_slot == SLOT_W'(SAMPLES - 1)) ? '0 : write_slot + 1'b1;
  assign stamp_we  = pop && (head.op == OP_HALL_HIGH);

  // a new result is loaded by a quick request or by the end of a divide
  assign result_load = (pop && (head.op != OP_HALL_HIGH)) || ((state == S_DIV) && div_done);

  assign period    = (timeout_ticks == '0) ? TIMEOUT_W'(1) : timeout_ticks;
  assign tc_inc    = timeout_count + 1'b1;
  assign check_due = tc_inc >= period;

  // zero divisor and oversized quotients both clamp to the top speed
  always_comb begin
    if (prod == '0) begin
      speed_sat = RPM_MAX;
    end else if (32'(quotient) > 32'(RPM_MAX)) begin
      speed_sat = RPM_MAX;
    end else begin
      speed_sat = RPM_W'(quotient);
    end
  end

  htach_ram #(
    .WIDTH (TICK_W),
    .DEPTH (SAMPLES)
  ) u_ring (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (write_slot),
    .wdata (tick_count),
    .raddr (slot_next),
    .rdata (rd_data)
  );

  htach_div #(
    .NUMER (NUMER),
    .DIV_W (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (prod),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_count    <= '0;
      timeout_count <= '0;
      activity_seen <= 1'b0;
      speed_value   <= '0;
      write_slot    <= '0;
      stamp_valid   <= '0;
      old_valid     <= 1'b0;
      div_start     <= 1'b0;
      result_valid  <= 1'b0;
      rpm           <= '0;
      timed_out     <= 1'b0;
    end else begin
      div_start <= (state == S_MUL);
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_TICK: begin
                tick_count <= tick_count + 1'b1;
                if (check_due) begin
                  timeout_count <= '0;
                  activity_seen <= 1'b0;
                  if (!activity_seen) begin
                    speed_value <= '0;
                    rpm         <= '0;
                    timed_out   <= 1'b1;
                  end else begin
                    rpm       <= speed_value;
                    timed_out <= 1'b0;
                  end
                end else begin
                  timeout_count <= tc_inc;
                  rpm           <= speed_value;
                  timed_out     <= 1'b0;
                end
              end
              OP_HALL_HIGH: begin
                activity_seen           <= 1'b1;
                stamp_valid[write_slot] <= 1'b1;
                old_valid               <= stamp_valid[slot_next];
                write_slot              <= slot_next;
                state                   <= S_READ;
              end
              default: begin
                activity_seen <= 1'b1;
                rpm           <= speed_value;
                timed_out     <= 1'b0;
              end
            endcase
          end
        end
        S_READ: begin
          // slots never written read as zero through their cleared valid bit
          span  <= tick_count - (old_valid ? rd_data : '0);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= PROD_W'(span) * PROD_W'(tick_period_ms);
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            speed_value <= speed_sat;
            rpm         <= speed_sat;
            timed_out   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cleared_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && timed_out |-> rpm == '0)
    else $error("timeout result with nonzero speed");

  a_rpm_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> rpm <= RPM_MAX)
    else $error("speed above saturation limit");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    32'(write_slot) < SAMPLES)
    else $error("write slot out of ring");

  a_pop_progress: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != S_IDLE) || result_valid)
    else $error("request taken without result or work");

endmodule

FILE: test/tb.sv
// self-checking testbench for the hall sensor tachometer
`timescale 1ns / 1ps

module tb;
  import htach_pkg::*;

  localparam int RING_DEPTH  = 50;
  localparam int SPEED_NUMER = MS_PER_MINUTE * RING_DEPTH;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_ITEMS = 180;

  // request kinds on req_type
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_HALL = 1'b1;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             timed_out;
  } reading_t;

  // directed rows: register writes, requests with typed-in readings, predicted requests
  typedef enum logic [1:0] {ROW_REGS, ROW_CHECKED, ROW_PREDICTED} row_act_t;

  typedef struct packed {
    row_act_t         act;
    logic             kind;
    logic             level;
    logic [RPM_W-1:0] rpm;
    logic             timed_out;
    logic [15:0]      tmo;
    logic [15:0]      per;
  } row_t;

  localparam int DIR_ROWS = 24;
  localparam row_t DIR_TABLE [DIR_ROWS] = '{
    // fresh from reset: low hall only marks activity, a tick leaves speed at zero
    '{ROW_CHECKED,   REQ_HALL, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_CHECKED,   REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    // empty ring: the oldest stamp reads zero, span of one tick gives the top speed
    '{ROW_CHECKED,   REQ_HALL, 1'b1, RPM_MAX, 1'b0, 16'd0, 16'd0},
    '{ROW_CHECKED,   REQ_HALL, 1'b1, RPM_MAX, 1'b0, 16'd0, 16'd0},
    // zero timeout acts as one: a check on every tick
    '{ROW_REGS,      REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd1},
    '{ROW_CHECKED,   REQ_TICK, 1'b1, RPM_MAX, 1'b0, 16'd0, 16'd0},
    '{ROW_CHECKED,   REQ_TICK, 1'b0, 22'd0,   1'b1, 16'd0, 16'd0},
    '{ROW_CHECKED,   REQ_TICK, 1'b1, 22'd0,   1'b1, 16'd0, 16'd0},
    // zero tick period: zero divisor saturates
    '{ROW_REGS,      REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_CHECKED,   REQ_HALL, 1'b1, RPM_MAX, 1'b0, 16'd0, 16'd0},
    '{ROW_CHECKED,   REQ_TICK, 1'b0, RPM_MAX, 1'b0, 16'd0, 16'd0},
    // all-ones data: top timeout, period masked to its ten bits
    '{ROW_REGS,      REQ_TICK, 1'b0, 22'd0,   1'b0, 16'hFFFF, 16'hFFFF},
    '{ROW_PREDICTED, REQ_HALL, 1'b1, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_HALL, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_TICK, 1'b1, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_HALL, 1'b1, 22'd0,   1'b0, 16'd0, 16'd0},
    // smallest timeout, longest legal tick period
    '{ROW_REGS,      REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd1, 16'd1000},
    '{ROW_PREDICTED, REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_HALL, 1'b1, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_HALL, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0},
    '{ROW_PREDICTED, REQ_TICK, 1'b0, 22'd0,   1'b0, 16'd0, 16'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic                   req_type;
  logic                   hall_level;
  logic                   result_valid;
  logic                   result_stall;
  logic [RPM_W-1:0]       rpm;
  logic                   timed_out;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor state: stamp ring, counters, speed and register copies
  logic [TICK_W-1:0]    ring_stamps [RING_DEPTH];
  logic [5:0]           ring_slot;
  logic [TICK_W-1:0]    tick_total;
  logic [TIMEOUT_W-1:0] check_count;
  logic                 hall_seen;
  logic [RPM_W-1:0]     speed_now;
  logic [TIMEOUT_W-1:0] timeout_reg;
  logic [PERIOD_W-1:0]  period_reg;

  // readings still owed by the block, oldest first
  reading_t    speed_due [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // sender shaping
  int unsigned burst_left = 0;
  int unsigned phase_sent = 0;
  bit          no_gaps = 1'b0;
  bit          long_hold_due = 1'b0;

  hall_tachometer_rpm #(.SAMPLES(RING_DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .req_type     (req_type),
    .hall_level   (hall_level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .rpm          (rpm),
    .timed_out    (timed_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // advance the speed meter by one request and return the reading it produces
  function automatic reading_t spin_update(input logic kind, input logic level);
    reading_t             r;
    logic [TIMEOUT_W-1:0] check_limit;
    int unsigned          next_slot;
    logic [TICK_W-1:0]    span;
    logic [63:0]          divisor;
    logic [63:0]          quot;
    r.timed_out = 1'b0;
    if (kind == REQ_TICK) begin
      // a zero timeout register still means a check every tick
      check_limit = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;
      tick_total  = tick_total + 1'b1;
      check_count = check_count + 1'b1;
      if (check_count >= check_limit) begin
        check_count = '0;
        if (!hall_seen) begin
          speed_now   = '0;
          r.timed_out = 1'b1;
        end
        hall_seen = 1'b0;
      end
    end else begin
      hall_seen = 1'b1;
      if (level) begin
        next_slot = (ring_slot + 1 >= RING_DEPTH) ? 0 : ring_slot + 1;
        ring_stamps[ring_slot] = tick_total;
        // span wraps at 32 bits, the product with the period does not
        span    = tick_total - ring_stamps[next_slot];
        divisor = 64'(span) * 64'(period_reg);
        if (divisor == 64'd0) begin
          quot = 64'(RPM_MAX);
        end else begin
          quot = 64'(SPEED_NUMER) / divisor;
          if (quot > 64'(RPM_MAX)) quot = 64'(RPM_MAX);
        end
        speed_now = quot[RPM_W-1:0];
        ring_slot = 6'(next_slot);
      end
    end
    r.rpm = speed_now;
    return r;
  endfunction

  // offer one request, hold it until taken, then log what it must produce
  task automatic send_req(input logic kind, input logic level, input bit typed,
                          input reading_t typed_val);
    reading_t want;
    item_valid <= 1'b1;
    req_type   <= kind;
    hall_level <= level;
    do @(posedge clk); while (item_stall);
    want = spin_update(kind, level);
    speed_due.push_back(typed ? typed_val : want);
  endtask

  // random request with burst and gap shaping on the sender side
  task automatic offer(input logic kind, input logic level);
    int unsigned gap;
    send_req(kind, level, 1'b0, '0);
    phase_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for every owed reading
  task automatic settle();
    item_valid <= 1'b0;
    while (speed_due.size() != 0) @(posedge clk);
  endtask

  // write both registers back to back, timeout first
  task automatic write_regs(input logic [15:0] tmo, input logic [15:0] per);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    do @(posedge clk); while (!cfg_ready);
    timeout_reg = tmo;
    cfg_index <= CFG_PERIOD;
    cfg_data  <= per;
    do @(posedge clk); while (!cfg_ready);
    period_reg = per[PERIOD_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // one register setting followed by a stream of mostly well-formed rotation
  task automatic run_phase(input logic [15:0] tmo, input logic [15:0] per,
                           input int unsigned spread, input int unsigned n_items);
    int unsigned pick;
    int unsigned quiet;
    settle();
    write_regs(tmo, per);
    phase_sent = 0;
    burst_left = $urandom_range(1, 24);
    while (phase_sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // rotation step: some ticks, maybe a falling edge, then a rising edge
        repeat ($urandom_range(0, spread)) offer(REQ_TICK, 1'($urandom));
        if ($urandom_range(0, 3) == 0) offer(REQ_HALL, 1'b0);
        offer(REQ_HALL, 1'b1);
      end else if (pick < 85) begin
        offer(1'($urandom), 1'($urandom));
      end else if (pick < 95) begin
        // stalled rotor: enough ticks to run past a few checks when the timeout is short
        quiet = (timeout_reg > 16'd20) ? 20 : timeout_reg + 1;
        repeat ($urandom_range(1, 3 * quiet)) offer(REQ_TICK, 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) offer(REQ_HALL, 1'b0);
      end
    end
  endtask

  // receiver: stall style changes per segment, plus one long hold on request
  initial begin : result_side
    int unsigned seg_left;
    int unsigned style;
    int unsigned hold_left;
    seg_left  = 0;
    style     = 0;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(0, 3);
          seg_left = $urandom_range(4, 60);
        end
        seg_left--;
        case (style)
          0: begin
            result_stall <= 1'b0;
          end
          1: begin
            result_stall <= ($urandom_range(0, 99) < 30);
          end
          2: begin
            result_stall <= ($urandom_range(0, 99) < 80);
          end
          default: begin
            result_stall <= seg_left[0];
          end
        endcase
      end
    end
  end

  // result checker: every accepted reading against the oldest owed one
  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_valid && !result_stall) begin
      if (speed_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: rpm %0d timed_out %0b", rpm, timed_out);
      end else begin
        want = speed_due.pop_front();
        if (rpm !== want.rpm || timed_out !== want.timed_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rpm %0d timed_out %0b, expected rpm %0d timed_out %0b",
                     rpm, timed_out, want.rpm, want.timed_out);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    reading_t typed_row;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    req_type   <= REQ_TICK;
    hall_level <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_TIMEOUT;
    cfg_data   <= '0;

    // predictor starts from the reset state
    foreach (ring_stamps[i]) ring_stamps[i] = '0;
    ring_slot   = '0;
    tick_total  = '0;
    check_count = '0;
    hall_seen   = 1'b0;
    speed_now   = '0;
    timeout_reg = TIMEOUT_RESET;
    period_reg  = PERIOD_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].act == ROW_REGS) begin
        settle();
        write_regs(DIR_TABLE[i].tmo, DIR_TABLE[i].per);
      end else begin
        typed_row.rpm       = DIR_TABLE[i].rpm;
        typed_row.timed_out = DIR_TABLE[i].timed_out;
        send_req(DIR_TABLE[i].kind, DIR_TABLE[i].level, DIR_TABLE[i].act == ROW_CHECKED,
                 typed_row);
      end
    end

    // random phases, each under its own register setting
    run_phase(16'd3, 16'd1, 2, PHASE_ITEMS);
    run_phase(16'd0, 16'd1000, 6, PHASE_ITEMS);
    run_phase(16'hFFFF, 16'($urandom), 20, PHASE_ITEMS);
    run_phase(16'd1, 16'd0, 3, PHASE_ITEMS);
    run_phase(16'($urandom), 16'($urandom_range(1, 1000)), 8, PHASE_ITEMS);

    // back-pressure: receiver holds off while requests keep coming back to back,
    // then the sender pauses until the block has drained
    no_gaps       = 1'b1;
    long_hold_due = 1'b1;
    run_phase(16'd10, 16'd7, 4, PHASE_ITEMS / 2);
    run_phase(16'd10, 16'd7, 4, PHASE_ITEMS / 2);
    no_gaps = 1'b0;

    run_phase(16'($urandom_range(1, 20)), 16'($urandom), 12, PHASE_ITEMS);
    run_phase(16'd5, 16'd1, 1, PHASE_ITEMS);

    // drain, then give the back end time to show any stray result
    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    mismatches += speed_due.size();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/htach_pkg.sv
hdl/htach_ram.sv
hdl/htach_front.sv
hdl/htach_div.sv
hdl/htach_back.sv
hdl/hall_tachometer_rpm.sv
test/tb.sv
